@@ hdl/tss_pkg.sv @@
`timescale 1ns / 1ps

package tss_pkg;

    // Table geometry and field widths
    localparam int C_MAX_TASKS = 16;
    localparam int C_IDX_W     = $clog2(C_MAX_TASKS);
    localparam int C_CNT_W     = $clog2(C_MAX_TASKS + 1);
    localparam int C_PRIO_W    = 8;

    typedef logic [C_IDX_W-1:0]  t_idx;
    typedef logic [C_CNT_W-1:0]  t_cnt;
    typedef logic [C_PRIO_W-1:0] t_prio;

    // Item kinds carried in tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_SCHED = 1'b1;

    // Scheduling policies
    localparam logic POLICY_RR   = 1'b0;
    localparam logic POLICY_PRIO = 1'b1;

    // Register indexes on the configuration port
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    // One task entry as stored in the table
    typedef struct packed {
        logic  ready;
        t_prio prio;
        logic  idle;
    } t_entry;

    // Table write port
    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_wr_req;

    // Table read port
    typedef struct packed {
        logic en;
        t_idx addr;
    } t_rd_req;

    // Start of a schedule decision
    typedef struct packed {
        logic start;
        logic mode;
        t_cnt count;
    } t_sched_req;

    // Status and result of the sequencer
    typedef struct packed {
        logic idle;
        logic done;
        t_idx chosen;
    } t_sched_rsp;

endpackage

@@ hdl/tss_table.sv @@
`timescale 1ns / 1ps

module tss_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tss_pkg::t_wr_req i_wr,
    input  tss_pkg::t_rd_req i_rd,
    output tss_pkg::t_entry  o_entry
);

    tss_pkg::t_entry r_mem [tss_pkg::C_MAX_TASKS];
    logic [tss_pkg::C_MAX_TASKS-1:0] r_valid;
    tss_pkg::t_entry r_rd_data;
    logic            r_rd_valid;

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Write the entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read of the entry storage
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data  <= r_mem[i_rd.addr];
            r_rd_valid <= r_valid[i_rd.addr];
        end
    end

    // Entries never written read as cleared
    assign o_entry = r_rd_valid ? r_rd_data : '0;

endmodule

@@ hdl/tss_seq.sv @@
`timescale 1ns / 1ps

module tss_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tss_pkg::t_sched_req i_req,
    input  logic                i_out_free,
    input  tss_pkg::t_entry     i_entry,
    output tss_pkg::t_rd_req    o_rd,
    output tss_pkg::t_sched_rsp o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state          r_state, n_state;
    logic            r_mode, n_mode;
    tss_pkg::t_cnt   r_count, n_count;
    tss_pkg::t_cnt   r_wrap, n_wrap;
    tss_pkg::t_cnt   r_left, n_left;
    tss_pkg::t_idx   r_addr, n_addr;
    logic            r_pend, n_pend;
    tss_pkg::t_idx   r_pend_addr, n_pend_addr;
    tss_pkg::t_idx   r_best, n_best;
    tss_pkg::t_prio  r_best_prio, n_best_prio;
    tss_pkg::t_idx   r_running, n_running;

    logic            w_hit;
    logic            w_issue;
    tss_pkg::t_cnt   w_next;

    // Round-robin hit on the entry that just came back
    assign w_hit   = r_pend && (r_mode == tss_pkg::POLICY_RR) && (i_entry.ready || i_entry.idle);
    assign w_issue = (r_state == ST_SCAN) && (r_left != '0) && !w_hit;
    assign w_next  = {1'b0, r_addr} + tss_pkg::t_cnt'(1);

    assign o_rd.en   = w_issue;
    assign o_rd.addr = r_addr;

    assign o_rsp.idle   = (r_state == ST_IDLE);
    assign o_rsp.done   = (r_state == ST_DONE) && i_out_free;
    assign o_rsp.chosen = r_best;

    // Next-state logic of the scan
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_wrap      = r_wrap;
        n_left      = r_left;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_best      = r_best;
        n_best_prio = r_best_prio;
        n_running   = r_running;
        case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_mode  = i_req.mode;
                    n_count = i_req.count;
                    n_best  = '0;
                    if (i_req.mode == tss_pkg::POLICY_PRIO) begin
                        n_addr  = '0;
                        n_left  = i_req.count;
                        n_state = ST_SCAN;
                    end else begin
                        n_wrap  = {1'b0, r_running} + tss_pkg::t_cnt'(1);
                        n_state = ST_WRAP;
                    end
                end
            end
            ST_WRAP: begin
                // Reduce running+1 modulo the count by repeated subtraction
                if (r_wrap >= r_count) begin
                    n_wrap = r_wrap - r_count;
                end else begin
                    n_addr  = r_wrap[tss_pkg::C_IDX_W-1:0];
                    n_left  = r_count - tss_pkg::t_cnt'(1);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Evaluate the entry read last cycle
                if (r_pend) begin
                    if (r_mode == tss_pkg::POLICY_RR) begin
                        if (w_hit) begin
                            n_best = r_pend_addr;
                        end
                    end else if (r_pend_addr == '0) begin
                        n_best      = '0;
                        n_best_prio = i_entry.prio;
                    end else if (i_entry.ready && (i_entry.prio < r_best_prio)) begin
                        n_best      = r_pend_addr;
                        n_best_prio = i_entry.prio;
                    end
                end
                // Issue the next read
                if (w_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_addr;
                    n_left      = r_left - tss_pkg::t_cnt'(1);
                    if ((r_mode == tss_pkg::POLICY_RR) && (w_next == r_count)) begin
                        n_addr = '0;
                    end else begin
                        n_addr = w_next[tss_pkg::C_IDX_W-1:0];
                    end
                end
                if (w_hit || ((r_left == '0) && !r_pend)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold the result until the output register frees up
                if (i_out_free) begin
                    n_running = r_best;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pend    <= 1'b0;
            r_running <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_running <= n_running;
        end
        r_mode      <= n_mode;
        r_count     <= n_count;
        r_wrap      <= n_wrap;
        r_left      <= n_left;
        r_addr      <= n_addr;
        r_pend_addr <= n_pend_addr;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
    end

endmodule

@@ hdl/task_scheduler_select_top.sv @@
`timescale 1ns / 1ps

// Task scheduler select. Keeps a table of 16 task entries (ready flag,
// priority, idle mark) in a synchronous RAM with one write and one read
// port plus the running task index. A write item (tuser 0) stores one
// entry and gives no result. A schedule item (tuser 1) picks the next task
// in round-robin or lowest-number priority order, returns its index on the
// output stream and makes it the running task. One item is in work at a
// time; the output register lets the next item be taken while a result
// still waits. A schedule decision reads the table one entry per cycle
// through the single RAM read port. With n installed tasks (n at most 16),
// round-robin mode first wraps running+1 into the range 0 to n-1 by
// repeated subtraction before it reads the table. Entries read as cleared
// until written after reset; no clearing pass is needed.

module task_scheduler_select_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] task_index, [4] ready_flag, [12:5] priority_level, [13] idle_mark
    input  logic [15:0] s_axis_tdata,
    // [0] kind
    input  logic [0:0]  s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] chosen_task
    output logic [7:0]  m_axis_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                r_policy;
    tss_pkg::t_cnt       r_count;
    logic                r_out_vld;
    tss_pkg::t_idx       r_out_task;

    logic                w_accept;
    logic                w_cfg_wr;
    logic                w_out_free;
    tss_pkg::t_cnt       w_count_sat;
    tss_pkg::t_wr_req    w_wr;
    tss_pkg::t_rd_req    w_rd;
    tss_pkg::t_entry     w_entry;
    tss_pkg::t_sched_req w_req;
    tss_pkg::t_sched_rsp w_rsp;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= tss_pkg::POLICY_RR;
            r_count  <= tss_pkg::t_cnt'(1);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                tss_pkg::REG_POLICY: r_policy <= pwdata[0];
                tss_pkg::REG_COUNT:  r_count  <= pwdata[tss_pkg::C_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tss_pkg::REG_POLICY: prdata = {31'b0, r_policy};
            tss_pkg::REG_COUNT:  prdata = {{(32 - tss_pkg::C_CNT_W){1'b0}}, r_count};
            default:             prdata = '0;
        endcase
    end

    // Saturate the installed count to 1..MAX_TASKS
    always_comb begin
        if (r_count == '0) begin
            w_count_sat = tss_pkg::t_cnt'(1);
        end else if (r_count > tss_pkg::t_cnt'(tss_pkg::C_MAX_TASKS)) begin
            w_count_sat = tss_pkg::t_cnt'(tss_pkg::C_MAX_TASKS);
        end else begin
            w_count_sat = r_count;
        end
    end

    // Input transfer: write items go to the table, schedule items start a scan
    assign s_axis_tready = w_rsp.idle;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_wr.en         = w_accept && (s_axis_tuser[0] == tss_pkg::KIND_WRITE);
    assign w_wr.addr       = s_axis_tdata[3:0];
    assign w_wr.data.ready = s_axis_tdata[4];
    assign w_wr.data.prio  = s_axis_tdata[12:5];
    assign w_wr.data.idle  = s_axis_tdata[13];

    assign w_req.start = w_accept && (s_axis_tuser[0] == tss_pkg::KIND_SCHED);
    assign w_req.mode  = r_policy;
    assign w_req.count = w_count_sat;

    tss_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_entry (w_entry)
    );

    tss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_out_free (w_out_free),
        .i_entry    (w_entry),
        .o_rd       (w_rd),
        .o_rsp      (w_rsp)
    );

    // Output register: load on a finished decision, drop on transfer
    assign w_out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_rsp.done) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.done) begin
            r_out_task <= w_rsp.chosen;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0, r_out_task};

    // A decision never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (!r_out_vld || m_axis_tready))
        else $error("result overwritten in output register");

    // A schedule transfer makes the block busy
    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser[0] == tss_pkg::KIND_SCHED)) |=> !s_axis_tready)
        else $error("schedule item did not start a scan");

    // A write transfer leaves the input ready for the next item
    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser[0] == tss_pkg::KIND_WRITE)) |=> s_axis_tready)
        else $error("write item blocked the input");

    // Table reads happen only while a scan is running
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd.en |-> !w_rsp.idle)
        else $error("table read outside a scan");

endmodule
